FILE: rtl/chcb_pkg.sv
// Package for the canonical Huffman code builder.
// Holds the operation, status and register codes, the sequencer states and
// the table index result type. It has no dependencies.
package chcb_pkg;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_COUNT  = 2'd1,
        OP_SYMBOL = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_EXHAUSTED = 2'd2,
        ST_BEYOND    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_AC_MODE       = 2'd0,
        CFG_SYMBOL_COUNT  = 2'd1,
        CFG_TABLE_ENTRIES = 2'd2
    } cfg_index_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_SKIP = 1'b1
    } state_t;

    localparam logic [7:0] AC_SIZES     = 8'd11;
    localparam logic [7:0] NIBBLE_MASK  = 8'h0F;
    localparam logic [7:0] RST_SYM_CNT  = 8'd162;
    localparam logic [7:0] RST_TBL_ENT  = 8'd176;

    typedef struct packed {
        logic [7:0] index;
        logic       in_range;
    } idx_result_t;

endpackage

FILE: rtl/canonical_huffman_code_builder.sv
// Top level of the canonical Huffman code builder: sequencer, state and
// output register. Uses chcb_pkg, chcb_count_store and chcb_index_unit.
//
// Start and count items are taken while the sequencer is idle. A symbol item
// is accepted, then steps to the next code length as needed (at most
// MAX_CODE_LEN steps), then delivers its result. The single shift-and-load
// step walks one code length per cycle. A result waits in the output register
// while the next item is accepted; a symbol whose result is ready holds until
// that register is free. Count items with a length index of 0 or above
// MAX_CODE_LEN, and op code 3, are ignored.
module canonical_huffman_code_builder
    import chcb_pkg::*;
#(
    parameter int MAX_CODE_LEN = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [4:0]  length_index,
    input  logic [7:0]  item_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  table_index,
    output logic [4:0]  code_length,
    output logic [15:0] code_word,
    output logic        write_enable,
    output logic [1:0]  status
);

    localparam int CNT_AW = (MAX_CODE_LEN > 1) ? $clog2(MAX_CODE_LEN) : 1;
    localparam logic [4:0] MAX_LEN = 5'(MAX_CODE_LEN);

    logic        ac_mode_reg;
    logic [7:0]  sym_cnt_reg;
    logic [7:0]  tbl_ent_reg;

    state_t      state_reg, state_next;
    logic [4:0]  cur_len_reg, cur_len_next;
    logic [7:0]  remain_reg, remain_next;
    logic [15:0] code_reg, code_next;
    logic [7:0]  seen_reg, seen_next;
    logic [7:0]  sym_reg, sym_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_idx_reg, out_idx_next;
    logic [4:0]  out_len_reg, out_len_next;
    logic [15:0] out_code_reg, out_code_next;
    logic        out_we_reg, out_we_next;
    status_t     out_st_reg, out_st_next;

    logic              accept;
    logic              out_free;
    logic              cnt_wr;
    logic [4:0]        li_m1;
    logic [7:0]        cnt_rd;
    idx_result_t       idx_res;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign li_m1    = length_index - 5'd1;
    assign cnt_wr   = accept && (op_t'(op) == OP_COUNT) && (length_index != 5'd0)
                      && (length_index <= MAX_LEN);

    // The count store is addressed with the next value of the current length, so
    // its registered output holds the count for the length that the next step enters.
    chcb_count_store #(
        .WIDTH (8),
        .DEPTH (MAX_CODE_LEN),
        .AW    (CNT_AW)
    ) u_counts (
        .clk     (clk),
        .wr_en   (cnt_wr),
        .wr_addr (li_m1[CNT_AW-1:0]),
        .wr_data (item_value),
        .rd_addr (cur_len_next[CNT_AW-1:0]),
        .rd_data (cnt_rd)
    );

    chcb_index_unit u_index (
        .ac_mode       (ac_mode_reg),
        .symbol        (sym_reg),
        .table_entries (tbl_ent_reg),
        .result        (idx_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ac_mode_reg <= 1'b0;
            sym_cnt_reg <= RST_SYM_CNT;
            tbl_ent_reg <= RST_TBL_ENT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_AC_MODE:       ac_mode_reg <= cfg_data[0];
                CFG_SYMBOL_COUNT:  sym_cnt_reg <= cfg_data;
                CFG_TABLE_ENTRIES: tbl_ent_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_len_reg   <= 5'd0;
            remain_reg    <= 8'd0;
            code_reg      <= 16'd0;
            seen_reg      <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_len_reg   <= cur_len_next;
            remain_reg    <= remain_next;
            code_reg      <= code_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg      <= sym_next;
        out_idx_reg  <= out_idx_next;
        out_len_reg  <= out_len_next;
        out_code_reg <= out_code_next;
        out_we_reg   <= out_we_next;
        out_st_reg   <= out_st_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_len_next   = cur_len_reg;
        remain_next    = remain_reg;
        code_next      = code_reg;
        seen_next      = seen_reg;
        sym_next       = sym_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_idx_next   = out_idx_reg;
        out_len_next   = out_len_reg;
        out_code_next  = out_code_reg;
        out_we_next    = out_we_reg;
        out_st_next    = out_st_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (op_t'(op))
                        OP_START:
                        begin
                            cur_len_next = 5'd0;
                            remain_next  = 8'd0;
                            code_next    = 16'd0;
                            seen_next    = 8'd0;
                        end
                        OP_COUNT:  ;
                        OP_SYMBOL:
                        begin
                            sym_next   = item_value;
                            state_next = S_SKIP;
                        end
                        default:   ;
                    endcase
                end
            end
            S_SKIP:
            begin
                priority if (seen_reg >= sym_cnt_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_idx_next   = 8'd0;
                        out_len_next   = 5'd0;
                        out_code_next  = 16'd0;
                        out_we_next    = 1'b0;
                        out_st_next    = ST_BEYOND;
                        state_next     = S_IDLE;
                    end
                end
                else if (remain_reg != 8'd0)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_idx_next   = idx_res.index;
                        out_len_next   = cur_len_reg;
                        out_code_next  = code_reg;
                        out_we_next    = idx_res.in_range;
                        out_st_next    = idx_res.in_range ? ST_OK : ST_RANGE;
                        remain_next    = remain_reg - 8'd1;
                        code_next      = code_reg + 16'd1;
                        seen_next      = seen_reg + 8'd1;
                        state_next     = S_IDLE;
                    end
                end
                else if (cur_len_reg >= MAX_LEN)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_idx_next   = 8'd0;
                        out_len_next   = 5'd0;
                        out_code_next  = 16'd0;
                        out_we_next    = 1'b0;
                        out_st_next    = ST_EXHAUSTED;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    // Step to the next length; the code doubles on every
                    // length after the first.
                    if (cur_len_reg != 5'd0)
                    begin
                        code_next = {code_reg[14:0], 1'b0};
                    end
                    remain_next  = cnt_rd;
                    cur_len_next = cur_len_reg + 5'd1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign table_index  = out_idx_reg;
    assign code_length  = out_len_reg;
    assign code_word    = out_code_reg;
    assign write_enable = out_we_reg;
    assign status       = out_st_reg;

endmodule

FILE: rtl/chcb_count_store.sv
// Small generic RAM with one write port and a registered read port.
// Depends on nothing; the instantiating module sets width, depth and address width.
module chcb_count_store #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/chcb_index_unit.sv
// Destination table index for a symbol byte and its range check.
// Uses chcb_pkg for the AC size and nibble mask constants and the result struct.
module chcb_index_unit
    import chcb_pkg::*;
(
    input  logic        ac_mode,
    input  logic [7:0]  symbol,
    input  logic [7:0]  table_entries,
    output idx_result_t result
);

    logic [7:0] run;
    logic [7:0] size;
    logic [7:0] index;

    // Run is at most 15, so run * 11 + size stays below 256.
    assign run   = {4'd0, symbol[7:4]};
    assign size  = symbol & NIBBLE_MASK;
    assign index = ac_mode ? 8'(run * AC_SIZES + size) : symbol;

    assign result.index    = index;
    assign result.in_range = (index < table_entries);

endmodule

FILE: bench/chcb_code_checker.sv
// Checker for the canonical Huffman code builder: watches the register port
// and both item channels, predicts each code item and compares it.
// Depends on chcb_pkg for the operation, status and register codes.
module chcb_code_checker
    import chcb_pkg::*;
#(
    parameter int MAX_LEN = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [1:0]        op,
    input  logic [4:0]        length_index,
    input  logic [7:0]        item_value,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [7:0]        table_index,
    input  logic [4:0]        code_length,
    input  logic [15:0]       code_word,
    input  logic              write_enable,
    input  logic [1:0]        status,
    output int                fail_count,
    output int                pending,
    output int                checked,
    output logic [3:0][31:0]  status_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0]  index;
        logic [4:0]  len;
        logic [15:0] code;
        logic        we;
        status_t     st;
    } code_entry_t;

    // Mirror of the registers and of the code generation state.
    logic        ac_runs;
    logic [7:0]  sym_limit;
    logic [7:0]  tbl_size;
    logic [7:0]  len_counts [16];
    logic [4:0]  walk_len;
    logic [7:0]  left_here;
    logic [15:0] code_acc;
    logic [7:0]  codes_issued;

    code_entry_t pending_codes [$];
    int          errors;
    int          compared;
    int          hits [4];

    function automatic code_entry_t assign_code(input logic [7:0] sym);
        code_entry_t r;
        logic [7:0]  idx;
        r = '0;
        if (codes_issued >= sym_limit) begin
            r.st = ST_BEYOND;
            return r;
        end
        // Walk past lengths with no codes left; the code doubles per length passed.
        while (left_here == 0) begin
            if (walk_len >= MAX_LEN) begin
                r.st = ST_EXHAUSTED;
                return r;
            end
            if (walk_len > 0)
                code_acc = code_acc << 1;
            left_here = len_counts[walk_len[3:0]];
            walk_len++;
        end
        idx = ac_runs ? 8'(sym[7:4]) * AC_SIZES + (sym & NIBBLE_MASK) : sym;
        r.index = idx;
        r.len = walk_len;
        r.code = code_acc;
        r.we = (idx < tbl_size);
        r.st = (idx < tbl_size) ? ST_OK : ST_RANGE;
        left_here--;
        code_acc++;
        codes_issued++;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin : monitor
        code_entry_t got;
        code_entry_t want;
        logic        bad;
        if (!rst_n) begin
            ac_runs = 1'b0;
            sym_limit = RST_SYM_CNT;
            tbl_size = RST_TBL_ENT;
            for (int i = 0; i < 16; i++)
                len_counts[i] = '0;
            walk_len = '0;
            left_here = '0;
            code_acc = '0;
            codes_issued = '0;
            pending_codes.delete();
            errors = 0;
            compared = 0;
            for (int i = 0; i < 4; i++)
                hits[i] = 0;
            fail_count <= 0;
            pending <= 0;
            checked <= 0;
            status_hits <= '0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index_t'(cfg_index))
                    CFG_AC_MODE:       ac_runs = cfg_data[0];
                    CFG_SYMBOL_COUNT:  sym_limit = cfg_data;
                    CFG_TABLE_ENTRIES: tbl_size = cfg_data;
                    default: ;
                endcase
            end

            if (out_valid && !out_stall) begin
                got.index = table_index;
                got.len = code_length;
                got.code = code_word;
                got.we = write_enable;
                got.st = status_t'(status);
                if (pending_codes.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%t: unexpected code item: index %0d len %0d code %h",
                                 $realtime, got.index, got.len, got.code,
                                 " we %b status %0d", got.we, got.st);
                end
                else begin
                    want = pending_codes.pop_front();
                    compared++;
                    hits[want.st]++;
                    bad = (got.index !== want.index) || (got.len !== want.len) ||
                          (got.code !== want.code) || (got.we !== want.we) ||
                          (got.st !== want.st);
                    if (bad) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("%t: code item %0d mismatch", $realtime, compared);
                            $display("    expected index %0d len %0d code %h we %b status %0d",
                                     want.index, want.len, want.code, want.we, want.st);
                            $display("    got      index %0d len %0d code %h we %b status %0d",
                                     got.index, got.len, got.code, got.we, got.st);
                        end
                    end
                end
            end

            if (in_valid && !in_stall) begin
                case (op)
                    OP_START: begin
                        walk_len = '0;
                        left_here = '0;
                        code_acc = '0;
                        codes_issued = '0;
                    end
                    OP_COUNT: begin
                        if (length_index >= 1 && length_index <= MAX_LEN)
                            len_counts[4'(length_index - 5'd1)] = item_value;
                    end
                    OP_SYMBOL: pending_codes.push_back(assign_code(item_value));
                    default: ;
                endcase
            end

            fail_count <= errors;
            pending <= pending_codes.size();
            checked <= compared;
            for (int i = 0; i < 4; i++)
                status_hits[i] <= hits[i];
        end
    end

endmodule

FILE: bench/tb.sv
// Top of the bench for the canonical Huffman code builder: clock, reset,
// register programming, item traffic with random gaps, and the verdict.
// Depends on chcb_pkg, the builder RTL and chcb_code_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import chcb_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int ITEM_GOAL      = 830;
    localparam int SETTLE_CYCLES  = 40;
    localparam int SQUEEZE_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 4000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  op = '0;
    logic [4:0]  length_index = '0;
    logic [7:0]  item_value = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  table_index;
    logic [4:0]  code_length;
    logic [15:0] code_word;
    logic        write_enable;
    logic [1:0]  status;

    int               fail_count;
    int               pending;
    int               checked;
    logic [3:0][31:0] status_hits;

    int items_sent = 0;
    int items_taken = 0;
    int phases = 0;
    bit steady = 1'b0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    canonical_huffman_code_builder u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .length_index (length_index),
        .item_value   (item_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .table_index  (table_index),
        .code_length  (code_length),
        .code_word    (code_word),
        .write_enable (write_enable),
        .status       (status)
    );

    chcb_code_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .length_index (length_index),
        .item_value   (item_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .table_index  (table_index),
        .code_length  (code_length),
        .code_word    (code_word),
        .write_enable (write_enable),
        .status       (status),
        .fail_count   (fail_count),
        .pending      (pending),
        .checked      (checked),
        .status_hits  (status_hits)
    );

    always @(posedge clk)
        if (in_valid && !in_stall)
            items_taken <= items_taken + 1;

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    task automatic offer_item(input logic [1:0] kind, input logic [4:0] len_sel,
                              input logic [7:0] value);
        int gap;
        in_valid <= 1'b1;
        op <= kind;
        length_index <= len_sel;
        item_value <= value;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic program_registers(input logic ac, input logic [7:0] limit,
                                     input logic [7:0] size);
        cfg_we <= 1'b1;
        cfg_index <= CFG_AC_MODE;
        cfg_data <= {7'd0, ac};
        @(posedge clk);
        cfg_index <= CFG_SYMBOL_COUNT;
        cfg_data <= limit;
        @(posedge clk);
        cfg_index <= CFG_TABLE_ENTRIES;
        cfg_data <= size;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait until every predicted code item has come back and the block is quiet.
    task automatic settle();
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Receiver: random stalls, plus a long hold-off every 350 items taken from the
    // 250th on, so that the block backs up into its input channel.
    initial begin : receiver
        int hold;
        int run;
        int next_squeeze;
        hold = 0;
        run = 0;
        next_squeeze = 250;
        forever begin
            @(posedge clk);
            if (hold > 0)
                hold--;
            else if (items_taken >= next_squeeze) begin
                out_stall <= 1'b1;
                hold = SQUEEZE_CYCLES;
                next_squeeze += 350;
            end
            else if (run > 0)
                run--;
            else if (out_stall || steady) begin
                out_stall <= 1'b0;
                run = $urandom_range(0, 12);
            end
            else begin
                out_stall <= 1'b1;
                run = pick_gap();
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("No item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        int         total;
        int         n;
        logic [7:0] cnt;
        logic       ac;
        logic [7:0] limit;
        logic [7:0] size;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: three length-1 codes oversubscribe the table, so the single
        // length-16 code wraps past 16 bits; then counts run out.
        program_registers(1'b0, 8'd5, 8'd200);
        for (int l = 1; l <= 16; l++)
            offer_item(OP_COUNT, 5'(l), (l == 1) ? 8'd3 : ((l == 16) ? 8'd1 : 8'd0));
        offer_item(OP_COUNT, 5'd0, 8'd255);
        offer_item(OP_COUNT, 5'd31, 8'd255);
        offer_item(OP_UNUSED, 5'd31, 8'd255);
        offer_item(OP_SYMBOL, 5'd0, 8'd0);
        offer_item(OP_SYMBOL, 5'd0, 8'd255);
        offer_item(OP_SYMBOL, 5'd0, 8'd7);
        offer_item(OP_SYMBOL, 5'd0, 8'd128);
        offer_item(OP_SYMBOL, 5'd0, 8'd1);
        settle();
        phases++;

        // Counts survive a start; AC indexing, range limit and symbol limit.
        program_registers(1'b1, 8'd2, 8'd176);
        offer_item(OP_START, 5'd0, 8'd0);
        offer_item(OP_SYMBOL, 5'd0, 8'hAF);
        offer_item(OP_SYMBOL, 5'd0, 8'hFF);
        offer_item(OP_SYMBOL, 5'd0, 8'h10);
        settle();
        phases++;

        while (items_sent < ITEM_GOAL) begin
            case (phases)
                2: begin ac = 1'b0; limit = 8'd255; size = 8'd255; end
                3: begin ac = 1'b1; limit = 8'd0;   size = 8'd0;   end
                4: begin ac = 1'b1; limit = 8'd255; size = 8'd176; end
                default: begin
                    ac = 1'($urandom);
                    n = $urandom_range(0, 9);
                    limit = (n < 3) ? 8'd255 : ((n < 5) ? 8'($urandom_range(0, 20))
                                                       : 8'($urandom));
                    n = $urandom_range(0, 9);
                    size = (n < 2) ? 8'd255 : ((n < 3) ? 8'd0
                                                       : 8'($urandom_range(100, 255)));
                end
            endcase
            program_registers(ac, limit, size);
            steady = ($urandom_range(0, 4) == 0);

            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 9) < 8) begin
                    // A table: start, counts per length (sometimes cut short), symbols.
                    total = 0;
                    offer_item(OP_START, 5'($urandom), 8'($urandom));
                    for (int l = 1; l <= 16; l++) begin
                        if (l > 1 && $urandom_range(0, 39) == 0)
                            break;
                        n = $urandom_range(0, 99);
                        if (n < 55)
                            cnt = 8'd0;
                        else if (n < 90)
                            cnt = 8'($urandom_range(1, 4));
                        else if (n < 97)
                            cnt = 8'($urandom_range(5, 12));
                        else
                            cnt = 8'd255;
                        total += cnt;
                        offer_item(OP_COUNT, 5'(l), cnt);
                    end
                    n = ((total > 20) ? 20 : total) + $urandom_range(0, 3);
                    repeat (n) begin
                        if ($urandom_range(0, 19) == 0) begin
                            if ($urandom_range(0, 1) == 0)
                                offer_item(OP_UNUSED, 5'($urandom), 8'($urandom));
                            else
                                offer_item(OP_COUNT,
                                           ($urandom_range(0, 15) == 0) ? 5'd0
                                               : 5'($urandom_range(17, 31)),
                                           8'($urandom));
                        end
                        offer_item(OP_SYMBOL, 5'($urandom), 8'($urandom));
                    end
                end
                else begin
                    // Noise: any op, any length index, any value.
                    repeat ($urandom_range(6, 15))
                        offer_item(2'($urandom), 5'($urandom), 8'($urandom));
                end
            end
            settle();
            phases++;
        end

        $display("Drove %0d items over %0d register settings; checked %0d code items.",
                 items_sent, phases, checked);
        $display("Status mix: ok %0d, out of range %0d, exhausted %0d, over limit %0d.",
                 status_hits[ST_OK], status_hits[ST_RANGE], status_hits[ST_EXHAUSTED],
                 status_hits[ST_BEYOND]);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
